// ===== hw/rtl/fqa_pkg.sv =====
package fqa_pkg;

  localparam int NUM_W      = 33;
  localparam int DEN_W      = 32;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int LVL_W      = NUM_W + 2;
  localparam int DIFF_W     = 18;
  localparam int PROD_W     = DIFF_W + DEN_W;

  localparam logic REG_QUANT_LOW  = 1'b0;
  localparam logic REG_QUANT_HIGH = 1'b1;

  localparam logic signed [15:0] QUANT_LOW_RST  = -16'sd128;
  localparam logic signed [15:0] QUANT_HIGH_RST = 16'sd127;

  localparam logic OP_FORWARD  = 1'b0;
  localparam logic OP_BACKWARD = 1'b1;

  typedef struct packed {
    logic               op;
    logic               neg;
    logic [30:0]        step;
    logic signed [15:0] offset;
    logic signed [31:0] grad;
  } side_t;

endpackage

// ===== hw/rtl/fqa_div.sv =====
module fqa_div import fqa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  side_t            side_in,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output side_t            side_out
);

  logic             valid_r [DIV_STAGES];
  logic [NUM_W-1:0] rem_r   [DIV_STAGES];
  logic [NUM_W-1:0] num_r   [DIV_STAGES];
  logic [NUM_W-1:0] quo_r   [DIV_STAGES];
  logic [DEN_W-1:0] den_r   [DIV_STAGES];
  side_t            side_r  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic             v_in;
    logic [NUM_W-1:0] rem_in, num_in, quo_in;
    logic [DEN_W-1:0] den_in;
    side_t            side_s;
    logic [NUM_W-1:0] rem_nxt, num_nxt, quo_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
      assign den_in = den;
      assign side_s = side_in;
    end else begin : g_next
      assign v_in   = valid_r[k-1];
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
      assign side_s = side_r[k-1];
    end

    always_comb begin
      logic [NUM_W-1:0] t;
      t       = '0;
      rem_nxt = rem_in;
      num_nxt = num_in;
      quo_nxt = quo_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (k * DIV_STEPS + j < NUM_W) begin
          t       = {rem_nxt[NUM_W-2:0], num_nxt[NUM_W-1]};
          num_nxt = {num_nxt[NUM_W-2:0], 1'b0};
          if (t >= {1'b0, den_in}) begin
            rem_nxt = t - {1'b0, den_in};
            quo_nxt = {quo_nxt[NUM_W-2:0], 1'b1};
          end else begin
            rem_nxt = t;
            quo_nxt = {quo_nxt[NUM_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_in;
      end
      if (en) begin
        rem_r[k]  <= rem_nxt;
        num_r[k]  <= num_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_s;
      end
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign quo       = quo_r[DIV_STAGES-1];
  assign side_out  = side_r[DIV_STAGES-1];

endmodule

// ===== hw/rtl/fqa_dequant.sv =====
module fqa_dequant import fqa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [NUM_W-1:0]   quo,
  input  side_t              side_in,
  input  logic signed [15:0] quant_low,
  input  logic signed [15:0] quant_high,
  output logic               out_valid,
  output logic [31:0]        result
);

  logic signed [LVL_W-1:0]  lvl, lo, hi, qc;
  logic signed [DIFF_W-1:0] diff;
  logic                     inr;

  logic                     va_r, vb_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [30:0]              step_r;
  logic                     op_r, inr_r, opb_r, inrb_r;
  logic signed [31:0]       grad_r, gradb_r;
  logic signed [PROD_W-1:0] prod_r;

  always_comb begin
    logic signed [LVL_W-1:0] qs;
    qs = side_in.neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    lo = LVL_W'(quant_low);
    hi = LVL_W'(quant_high);
    lvl = qs + LVL_W'(side_in.offset);
    inr = (lvl >= lo) && (lvl <= hi);
    qc = lvl;
    if (qc <= lo) qc = lo;
    if (qc >= hi) qc = hi;
    diff = DIFF_W'(qc) - DIFF_W'(side_in.offset);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
    if (en) begin
      diff_r  <= diff;
      step_r  <= side_in.step;
      op_r    <= side_in.op;
      inr_r   <= inr;
      grad_r  <= side_in.grad;
      prod_r  <= PROD_W'(diff_r) * $signed({1'b0, step_r});
      opb_r   <= op_r;
      inrb_r  <= inr_r;
      gradb_r <= grad_r;
    end
  end

  always_comb begin
    if (opb_r == OP_BACKWARD) begin
      result = inrb_r ? gradb_r : 32'sd0;
    end else if (prod_r > PROD_W'(32'sh7fffffff)) begin
      result = 32'h7fffffff;
    end else if (prod_r < -PROD_W'(33'sh080000000)) begin
      result = 32'h80000000;
    end else begin
      result = prod_r[31:0];
    end
  end

  assign out_valid = vb_r;

endmodule

// ===== hw/rtl/fake_quantize_affine.sv =====
// Fake affine quantization of Q16.16 words, one word per cycle when the
// output is not stalled. The stages are an input register, a restoring
// divider pipelined four quotient bits per stage, a clamp stage, a
// multiply stage and the output register. The whole pipeline holds
// while out_tready is low with a word waiting.
module fake_quantize_affine import fqa_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sample_value[31:0], step_size[62:32], level_offset[78:63],
  // upstream_grad[110:79], zero pad
  input  logic [111:0] in_tdata,
  // operation
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_value
  output logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [15:0]  cfg_data
);

  logic                     en;
  logic signed [15:0]       quant_low_r, quant_high_r;
  logic                     v0_r;
  logic [NUM_W-1:0]         num_r;
  logic [DEN_W-1:0]         den_r;
  side_t                    side0_r, side0_nxt, sided;
  logic [NUM_W-1:0]         num_nxt, quo;
  logic [DEN_W-1:0]         den_nxt;
  logic                     vd, vq;
  logic [31:0]              res;
  logic                     out_tvalid_r;
  logic [31:0]              out_tdata_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_low_r  <= QUANT_LOW_RST;
      quant_high_r <= QUANT_HIGH_RST;
    end else if (cfg_we) begin
      if (cfg_idx == REG_QUANT_LOW) quant_low_r <= cfg_data;
      if (cfg_idx == REG_QUANT_HIGH) quant_high_r <= cfg_data;
    end
  end

  always_comb begin
    logic signed [31:0] v;
    logic [30:0]        s;
    logic [31:0]        mag;
    v   = in_tdata[31:0];
    s   = (in_tdata[62:32] == '0) ? 31'd1 : in_tdata[62:32];
    mag = v[31] ? (32'd0 - v) : v;
    num_nxt = {mag, 1'b0} + NUM_W'(s);
    den_nxt = {s, 1'b0};
    side0_nxt.op     = in_tuser;
    side0_nxt.neg    = v[31];
    side0_nxt.step   = s;
    side0_nxt.offset = in_tdata[78:63];
    side0_nxt.grad   = in_tdata[110:79];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
    if (en) begin
      num_r   <= num_nxt;
      den_r   <= den_nxt;
      side0_r <= side0_nxt;
    end
  end

  fqa_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v0_r), .num(num_r), .den(den_r), .side_in(side0_r),
    .out_valid(vd), .quo(quo), .side_out(sided)
  );

  fqa_dequant u_dequant (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vd), .quo(quo), .side_in(sided),
    .quant_low(quant_low_r), .quant_high(quant_high_r),
    .out_valid(vq), .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vq;
    end
    if (en) begin
      out_tdata_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_ready: assert property (@(posedge clk) in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow output stall");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_cfg_lo: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_idx == REG_QUANT_LOW |=> quant_low_r == $past(cfg_data))
    else $error("quant_low write lost");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_tdata_r) && $stable(v0_r))
    else $error("pipeline moved during stall");

endmodule

// ===== tb/tb_fake_quantize_affine.sv =====
module tb_fake_quantize_affine;
  import fqa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_idx = 1'b0;
  logic [15:0]  cfg_data = '0;

  typedef struct {
    logic               op;
    logic signed [31:0] sample;
    logic [30:0]        step;
    logic signed [15:0] offset;
    logic signed [31:0] grad;
    logic               known;
    logic signed [31:0] result;
  } vec_t;

  logic signed [15:0] lo_lvl, hi_lvl;
  logic [31:0]        expected_q[$];
  int                 mismatches = 0;
  int                 idle_cnt = 0;
  bit                 tail = 0;
  bit                 rx_stall_en = 1;

  fake_quantize_affine u_top (.*);

  always #5 clk = ~clk;

  function automatic logic signed [31:0] fq_value(vec_t v);
    logic signed [63:0]  val, q, r;
    logic [63:0]         mag, s, quo;
    s = (v.step == 0) ? 64'd1 : 64'(v.step);
    val = v.sample;
    mag = (val < 0) ? 64'(-val) : 64'(val);
    quo = (2 * mag + s) / (2 * s);
    q = ((val < 0) ? -$signed(quo) : $signed(quo)) + v.offset;
    if (v.op == OP_FORWARD) begin
      if (q <= lo_lvl) q = lo_lvl;
      if (q >= hi_lvl) q = hi_lvl;
      r = (q - v.offset) * $signed(s);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
    end else begin
      r = (q >= lo_lvl && q <= hi_lvl) ? 64'(v.grad) : 64'sd0;
    end
    return r[31:0];
  endfunction

  // receiver
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_tdata);
      end else begin
        logic [31:0] e;
        e = expected_q.pop_front();
        if (e !== out_tdata) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %h got %h", e, out_tdata);
        end
      end
    end
  end

  initial begin : rx_drive
    int n;
    forever begin
      @(posedge clk);
      if (!tail && rx_stall_en && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic signed [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_QUANT_LOW) lo_lvl = val;
    else hi_lvl = val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_word(vec_t v);
    logic [31:0] e;
    if (!tail && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    e = fq_value(v);
    if (v.known && e !== v.result) begin
      mismatches++;
      if (mismatches <= 10) $display("table exp %h pred %h", v.result, e);
    end
    in_tvalid <= 1'b1;
    in_tuser <= v.op;
    in_tdata <= {1'b0, v.grad, v.offset, v.step, v.sample};
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(e);
  endtask

  function automatic vec_t rand_vec();
    vec_t v;
    int k;
    v.op = 1'($urandom_range(0, 1));
    v.sample = $urandom;
    k = $urandom_range(0, 3);
    v.step = (k == 0) ? 31'($urandom) : (k == 1) ? 31'($urandom_range(0, 65535))
           : (k == 2) ? 31'($urandom_range(0, 2047) << 12) : 31'($urandom_range(0, 3));
    v.offset = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 60)) - 30);
    v.grad = $urandom;
    if ($urandom_range(0, 2) == 0)  // near a tie
      v.sample = 32'($signed(16'($urandom)) * $signed({1'b0, v.step})) + (v.step >> 1);
    v.known = 0;
    v.result = 0;
    return v;
  endfunction

  vec_t dir_tab[] = '{
    '{OP_FORWARD,  32'sd0,           31'd65536, 16'sd0, 32'sd5,  1, 32'sd0},
    '{OP_FORWARD,  32'sd98304,       31'd65536, 16'sd0, 32'sd0,  1, 32'sd131072},
    '{OP_FORWARD,  -32'sd98304,      31'd65536, 16'sd0, 32'sd0,  1, -32'sd131072},
    '{OP_FORWARD,  32'sd1000,        31'd0,     16'sd0, 32'sd0,  1, 32'sd127},
    '{OP_FORWARD,  32'h7fffffff,     31'd1,     16'sd0, 32'sd0,  1, 32'sd127},
    '{OP_FORWARD,  32'h80000000,     31'd1,     16'sd0, 32'sd0,  1, -32'sd128},
    '{OP_FORWARD,  32'h7fffffff,     31'h7fffffff, 16'sd0, 32'sd0, 1, 32'h7fffffff},
    '{OP_FORWARD,  32'h80000000,     31'h7fffffff, 16'sd0, 32'sd0, 1, 32'h80000001},
    '{OP_FORWARD,  32'h80000000,     31'h7fffffff, 16'sh7fff, 32'sd0, 0, 32'sd0},
    '{OP_FORWARD,  32'h7fffffff,     31'h7fffffff, 16'sh8000, 32'sd0, 0, 32'sd0},
    '{OP_BACKWARD, 32'sd0,           31'd65536, 16'sd0, 32'h7fffffff, 1, 32'h7fffffff},
    '{OP_BACKWARD, 32'sd0,           31'd65536, 16'sd0, 32'h80000000, 1, 32'h80000000},
    '{OP_BACKWARD, 32'h7fffffff,     31'd1,     16'sd0, 32'sd77, 1, 32'sd0},
    '{OP_BACKWARD, 32'sd0,           31'd1, 16'sd127, 32'sd9, 1, 32'sd9},
    '{OP_BACKWARD, 32'sd0,           31'd1, 16'sd128, 32'sd9, 1, 32'sd0},
    '{OP_BACKWARD, -32'sd1,          31'd2, 16'sd0, 32'sd3, 0, 32'sd0},
    '{OP_FORWARD,  32'sd3,           31'd2, 16'sd0, 32'sd0, 1, 32'sd4},
    '{OP_FORWARD,  -32'sd3,          31'd2, 16'sd0, 32'sd0, 1, -32'sd4}
  };

  initial begin : main
    lo_lvl = QUANT_LOW_RST;
    hi_lvl = QUANT_HIGH_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) send_word(dir_tab[i]);
    drain();
    // inverted bounds, then extremes, then 0 to 255 without receiver stalls, then random settings
    write_reg(REG_QUANT_LOW, 16'sd10);
    write_reg(REG_QUANT_HIGH, -16'sd10);
    for (int i = 0; i < 150; i++) send_word(rand_vec());
    drain();
    write_reg(REG_QUANT_LOW, 16'sh8000);
    write_reg(REG_QUANT_HIGH, 16'sh7fff);
    for (int i = 0; i < 300; i++) send_word(rand_vec());
    drain();
    rx_stall_en = 0;
    write_reg(REG_QUANT_LOW, 16'sd0);
    write_reg(REG_QUANT_HIGH, 16'sd255);
    for (int i = 0; i < 300; i++) send_word(rand_vec());
    drain();
    rx_stall_en = 1;
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_QUANT_LOW, 16'($urandom));
      write_reg(REG_QUANT_HIGH, 16'($urandom));
      if (p == 2) tail = 1;
      for (int i = 0; i < 230; i++) send_word(rand_vec());
      drain();
    end
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== fake_quantize_affine.f =====
hw/rtl/fqa_pkg.sv
hw/rtl/fqa_div.sv
hw/rtl/fqa_dequant.sv
hw/rtl/fake_quantize_affine.sv
tb/tb_fake_quantize_affine.sv
